// ===== rtl/hhfl_pkg.sv =====
// ----------------------------------------------------------------------------
// hhfl_pkg
// Shared types and constants of the HTTP header field locator.
// ----------------------------------------------------------------------------
package hhfl_pkg;

    localparam int MAX_BLOCK_BYTES = 8192;
    // position counter must hold MAX_BLOCK_BYTES itself
    localparam int POS_W  = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int OFF_W  = 13;
    localparam int KIND_W = 4;
    localparam int IDX_W  = 5;
    localparam int NAMES  = 8;

    localparam logic [KIND_W-1:0] KIND_REQ  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_NONE = 4'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 4'd9;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [2:0] {
        PH_REQ      = 3'd0,
        PH_NAME     = 3'd1,
        PH_SKIPWS   = 3'd2,
        PH_VALUE    = 3'd3,
        PH_SKIPLINE = 3'd4,
        PH_DONE     = 3'd5
    } t_phase;

    typedef struct packed {
        logic [NAMES-1:0]  cand;
        logic [KIND_W-1:0] kind;
    } t_match;

    typedef struct packed {
        logic              fin;
        logic [OFF_W-1:0]  len;
        logic [OFF_W-1:0]  off;
        logic [KIND_W-1:0] kind;
    } t_rec;

endpackage

// ===== rtl/http_header_field_locator.sv =====
// ----------------------------------------------------------------------------
// http_header_field_locator
// Locates request line and known header values in an HTTP header block.
// ----------------------------------------------------------------------------
// A record is registered into the output register, or into the skid entry while
// the sink stalls, when the word that completes it is accepted. Throughput: one
// byte word per cycle while the skid entry is empty, set by the single state
// update per word; a two-entry output stage holds results while the sink stalls.
// Reset (synchronous, active low) and every word marked tlast return the parser to the request line phase.
module http_header_field_locator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    input  logic        i_s_axis_tlast,   // block_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [3:0] field_kind, [16:4] value_offset,
                                          // [29:17] value_length, [31:30] zero
    output logic        o_m_axis_tlast    // finished
);

    localparam int OW = hhfl_pkg::OFF_W;

    hhfl_pkg::t_phase                 r_phase, n_phase;
    logic [hhfl_pkg::POS_W-1:0]       r_pos, n_pos;
    logic                             r_cr, n_cr;
    logic [hhfl_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [hhfl_pkg::NAMES-1:0]       r_cand, n_cand;
    logic [hhfl_pkg::KIND_W-1:0]      r_kind, n_kind;
    logic [OW-1:0]                    r_vstart, n_vstart;
    logic                             r_empty, n_empty;

    hhfl_pkg::t_rec                   r_out, r_skid, w_rec;
    logic                             r_out_valid, r_skid_valid;
    logic                             w_res;

    hhfl_pkg::t_match                 w_match;
    logic                             w_acc, w_take, w_crlf;
    logic [7:0]                       w_b;
    logic [OW-1:0]                    w_crpos;

    hhfl_name_match u_match (
        .i_cand  (r_cand),
        .i_idx   (r_idx),
        .i_byte  (w_b),
        .o_match (w_match)
    );

    assign o_s_axis_tready = !r_skid_valid;
    assign w_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_b     = i_s_axis_tdata;
    assign w_take  = (r_pos < hhfl_pkg::POS_W'(hhfl_pkg::MAX_BLOCK_BYTES));
    assign w_crlf  = r_cr && (w_b == hhfl_pkg::CH_LF);
    assign w_crpos = OW'(r_pos) - OW'(1);

    // result record for the accepted word
    always_comb begin
        w_res      = 1'b0;
        w_rec.kind = hhfl_pkg::KIND_END;
        w_rec.off  = '0;
        w_rec.len  = '0;
        w_rec.fin  = 1'b0;
        if (w_take && w_crlf) begin
            unique case (r_phase)
                hhfl_pkg::PH_REQ: begin
                    w_res      = 1'b1;
                    w_rec.kind = hhfl_pkg::KIND_REQ;
                    w_rec.len  = w_crpos;
                end
                hhfl_pkg::PH_NAME: begin
                    if (r_empty) begin
                        w_res     = 1'b1;
                        w_rec.fin = 1'b1;
                    end
                end
                hhfl_pkg::PH_VALUE: begin
                    w_res      = 1'b1;
                    w_rec.kind = r_kind;
                    w_rec.off  = r_vstart;
                    w_rec.len  = w_crpos - r_vstart;
                end
                hhfl_pkg::PH_SKIPWS, hhfl_pkg::PH_SKIPLINE, hhfl_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
        if (i_s_axis_tlast) begin
            if (w_res) begin
                w_rec.fin = 1'b1;
            end else if (r_phase != hhfl_pkg::PH_DONE) begin
                w_res     = 1'b1;
                w_rec.fin = 1'b1;
            end
        end
    end

    // parser state update
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_cr     = r_cr;
        n_idx    = r_idx;
        n_cand   = r_cand;
        n_kind   = r_kind;
        n_vstart = r_vstart;
        n_empty  = r_empty;
        if (w_take && r_phase != hhfl_pkg::PH_DONE) begin
            if (w_crlf) begin
                n_idx   = '0;
                n_cand  = '1;
                n_empty = 1'b1;
                n_cr    = 1'b0;
                n_phase = (r_phase == hhfl_pkg::PH_NAME && r_empty) ?
                          hhfl_pkg::PH_DONE : hhfl_pkg::PH_NAME;
            end else begin
                n_empty = r_empty && (w_b == hhfl_pkg::CH_CR) && !r_cr;
                unique case (r_phase)
                    hhfl_pkg::PH_NAME: begin
                        n_cand = w_match.cand;
                        if (w_b == hhfl_pkg::CH_COLON) begin
                            if (w_match.kind != hhfl_pkg::KIND_NONE) begin
                                n_kind  = w_match.kind;
                                n_phase = hhfl_pkg::PH_SKIPWS;
                            end else begin
                                n_phase = hhfl_pkg::PH_SKIPLINE;
                            end
                        end
                        if (r_idx != '1) begin
                            n_idx = r_idx + hhfl_pkg::IDX_W'(1);
                        end
                    end
                    hhfl_pkg::PH_SKIPWS: begin
                        if (w_b != hhfl_pkg::CH_SP && w_b != hhfl_pkg::CH_TAB) begin
                            n_vstart = OW'(r_pos);
                            n_phase  = hhfl_pkg::PH_VALUE;
                        end
                    end
                    hhfl_pkg::PH_REQ, hhfl_pkg::PH_VALUE, hhfl_pkg::PH_SKIPLINE,
                    hhfl_pkg::PH_DONE: begin
                    end
                    default: begin
                    end
                endcase
                n_cr = (w_b == hhfl_pkg::CH_CR);
            end
        end
        if (w_take) begin
            n_pos = r_pos + hhfl_pkg::POS_W'(1);
        end
        // block end: back to the request line
        if (i_s_axis_tlast) begin
            n_phase  = hhfl_pkg::PH_REQ;
            n_pos    = '0;
            n_cr     = 1'b0;
            n_idx    = '0;
            n_cand   = '1;
            n_kind   = '0;
            n_vstart = '0;
            n_empty  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hhfl_pkg::PH_REQ;
            r_pos    <= '0;
            r_cr     <= 1'b0;
            r_idx    <= '0;
            r_cand   <= '1;
            r_kind   <= '0;
            r_vstart <= '0;
            r_empty  <= 1'b1;
        end else if (w_acc) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_cr     <= n_cr;
            r_idx    <= n_idx;
            r_cand   <= n_cand;
            r_kind   <= n_kind;
            r_vstart <= n_vstart;
            r_empty  <= n_empty;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_acc && w_res) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (w_acc && w_res) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out <= w_rec;
            end else begin
                r_skid <= w_rec;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.len, r_out.off, r_out.kind};
    assign o_m_axis_tlast  = r_out.fin;

endmodule

// ===== rtl/hhfl_name_match.sv =====
// ----------------------------------------------------------------------------
// hhfl_name_match
// Parallel comparator of one name byte against the eight known field names.
// ----------------------------------------------------------------------------
module hhfl_name_match (
    input  logic [hhfl_pkg::NAMES-1:0] i_cand,
    input  logic [hhfl_pkg::IDX_W-1:0] i_idx,
    input  logic [7:0]                 i_byte,
    output hhfl_pkg::t_match           o_match
);

    // string literals are right-justified: first character sits highest
    localparam logic [16*8-1:0] NAME_STR [hhfl_pkg::NAMES] = '{
        128'("Host:"),
        128'("User-Agent:"),
        128'("Accept:"),
        128'("Accept-Language:"),
        128'("Accept-Encoding:"),
        128'("Content-Length:"),
        128'("Content-Type:"),
        128'("Connection:")
    };
    localparam logic [hhfl_pkg::IDX_W-1:0] NAME_LEN [hhfl_pkg::NAMES] = '{
        5'd5, 5'd11, 5'd7, 5'd16, 5'd16, 5'd15, 5'd13, 5'd11
    };

    logic [hhfl_pkg::NAMES-1:0] w_cand;
    logic [3:0]                 w_sel [hhfl_pkg::NAMES];

    always_comb begin
        for (int k = 0; k < hhfl_pkg::NAMES; k++) begin
            w_sel[k]  = 4'(NAME_LEN[k] - 5'd1 - i_idx);
            w_cand[k] = i_cand[k] && (i_idx < NAME_LEN[k]) &&
                        (NAME_STR[k][{w_sel[k], 3'b000} +: 8] == i_byte);
        end
    end

    // lowest surviving candidate wins
    always_comb begin
        o_match.cand = w_cand;
        o_match.kind = hhfl_pkg::KIND_NONE;
        for (int k = hhfl_pkg::NAMES - 1; k >= 0; k--) begin
            if (w_cand[k]) begin
                o_match.kind = hhfl_pkg::KIND_W'(k + 1);
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HTTP header field locator. Byte words of
// generated header blocks (well-formed requests, near-miss names, noise and
// truncated blocks) are streamed in under random back-pressure on both
// sides. A behavioural parser predicts the records, and each record that
// leaves the block is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 600;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    http_header_field_locator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    string hdr_names [hhfl_pkg::NAMES] = '{"Host:", "User-Agent:", "Accept:",
                                           "Accept-Language:", "Accept-Encoding:",
                                           "Content-Length:", "Content-Type:",
                                           "Connection:"};

    t_word            tx_q [$];
    hhfl_pkg::t_rec   rec_q [$];
    logic [7:0]       blk [$];
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               run_phase = 0;
    logic             rx_freeze = 1'b0;
    int               sent_cnt = 0;
    int               err_cnt = 0;
    int               cyc_cnt = 0;

    // parser state
    hhfl_pkg::t_phase ps_phase;
    int unsigned      ps_pos;
    bit               ps_cr;
    logic [4:0]       ps_idx;
    logic [7:0]       ps_cand;
    logic [3:0]       ps_kind;
    logic [12:0]      ps_vstart;
    bit               ps_blank;

    function automatic void start_line();
        ps_idx   = '0;
        ps_cand  = '1;
        ps_blank = 1'b1;
        ps_cr    = 1'b0;
    endfunction

    function automatic void parser_reset();
        ps_phase  = hhfl_pkg::PH_REQ;
        ps_pos    = 0;
        ps_kind   = '0;
        ps_vstart = '0;
        start_line();
    endfunction

    // one byte inside the size limit
    function automatic bit parse_byte(input logic [7:0] b, output hhfl_pkg::t_rec rec);
        logic [12:0] cr_at;
        logic [3:0]  hit;
        bit          got;
        int          k;
        rec = '0;
        if (ps_phase == hhfl_pkg::PH_DONE) return 1'b0;
        if (ps_cr && b == hhfl_pkg::CH_LF) begin
            cr_at = 13'(ps_pos - 1);
            if (ps_phase == hhfl_pkg::PH_NAME && ps_blank) begin
                rec.kind = hhfl_pkg::KIND_END;
                rec.fin  = 1'b1;
                start_line();
                ps_phase = hhfl_pkg::PH_DONE;
                return 1'b1;
            end
            got      = (ps_phase == hhfl_pkg::PH_REQ || ps_phase == hhfl_pkg::PH_VALUE);
            rec.kind = (ps_phase == hhfl_pkg::PH_REQ) ? hhfl_pkg::KIND_REQ : ps_kind;
            rec.off  = (ps_phase == hhfl_pkg::PH_REQ) ? '0 : ps_vstart;
            rec.len  = cr_at - rec.off;
            start_line();
            ps_phase = hhfl_pkg::PH_NAME;
            return got;
        end
        ps_blank = ps_blank && b == hhfl_pkg::CH_CR && !ps_cr;
        if (ps_phase == hhfl_pkg::PH_NAME) begin
            for (k = 0; k < hhfl_pkg::NAMES; k++) begin
                if (ps_cand[k] && (ps_idx >= hdr_names[k].len() || hdr_names[k][ps_idx] != b))
                    ps_cand[k] = 1'b0;
            end
            if (b == hhfl_pkg::CH_COLON) begin
                hit = '0;
                // lowest matching name wins
                for (k = hhfl_pkg::NAMES - 1; k >= 0; k--) begin
                    if (ps_cand[k]) hit = 4'(k + 1);
                end
                if (hit != '0) begin
                    ps_kind  = hit;
                    ps_phase = hhfl_pkg::PH_SKIPWS;
                end else begin
                    ps_phase = hhfl_pkg::PH_SKIPLINE;
                end
            end
            if (ps_idx < 5'd31) ps_idx++;
        end else if (ps_phase == hhfl_pkg::PH_SKIPWS) begin
            if (b != hhfl_pkg::CH_SP && b != hhfl_pkg::CH_TAB) begin
                ps_vstart = 13'(ps_pos);
                ps_phase  = hhfl_pkg::PH_VALUE;
            end
        end
        ps_cr = (b == hhfl_pkg::CH_CR);
        return 1'b0;
    endfunction

    function automatic bit predict_record(input logic [7:0] b, input logic last,
                                          output hhfl_pkg::t_rec rec);
        bit got;
        bit was_done;
        got      = 1'b0;
        was_done = (ps_phase == hhfl_pkg::PH_DONE);
        rec      = '0;
        if (ps_pos < hhfl_pkg::MAX_BLOCK_BYTES) begin
            got = parse_byte(b, rec);
            ps_pos++;
        end
        if (last) begin
            if (got) begin
                rec.fin = 1'b1;
            end else if (!was_done) begin
                rec      = '0;
                rec.kind = hhfl_pkg::KIND_END;
                rec.fin  = 1'b1;
                got      = 1'b1;
            end
            parser_reset();
        end
        return got;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
            err_cnt++;
        end
    endfunction

    // driver: hold a word until taken, then offer the next one
    always @(posedge i_clk) begin : drive
        hhfl_pkg::t_rec rec;
        t_word          w;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (predict_record(i_s_axis_tdata, i_s_axis_tlast, rec))
                    rec_q.push_back(rec);
                sent_cnt++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (tx_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    w = tx_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= w.data;
                    i_s_axis_tlast  <= w.last;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        hhfl_pkg::t_rec want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (rec_q.size() == 0) begin
                    $error("unexpected record: tdata=%h tlast=%b", o_m_axis_tdata,
                           o_m_axis_tlast);
                    err_cnt++;
                end else begin
                    want = rec_q.pop_front();
                    check_field("field_kind", want.kind, o_m_axis_tdata[3:0]);
                    check_field("value_offset", want.off, o_m_axis_tdata[16:4]);
                    check_field("value_length", want.len, o_m_axis_tdata[29:17]);
                    check_field("finished", want.fin, o_m_axis_tlast);
                    check_field("tdata padding", 0, o_m_axis_tdata[31:30]);
                end
            end
            i_m_axis_tready <= !rx_freeze && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // long sink stall while the source keeps offering words
    initial begin : rx_hold_off
        int base;
        while (run_phase != 3) @(posedge i_clk);
        base = sent_cnt;
        while (sent_cnt < base + 50) @(posedge i_clk);
        rx_freeze <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_freeze <= 1'b0;
    end

    task automatic add_str(string s);
        int i;
        for (i = 0; i < s.len(); i++) blk.push_back(s[i]);
    endtask

    task automatic add_crlf();
        blk.push_back(hhfl_pkg::CH_CR);
        blk.push_back(hhfl_pkg::CH_LF);
    endtask

    function automatic logic [7:0] pick_char(bit any_byte);
        if (any_byte) return 8'($urandom_range(255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic add_text(int n, bit no_colon);
        int         i;
        logic [7:0] c;
        for (i = 0; i < n; i++) begin
            c = pick_char(1'b0);
            if (no_colon && c == hhfl_pkg::CH_COLON) c = "-";
            blk.push_back(c);
        end
    endtask

    task automatic add_header_line();
        int    sel, k, i, n;
        string nm;
        sel = $urandom_range(9);
        k   = $urandom_range(hhfl_pkg::NAMES - 1);
        if (sel <= 4 || sel == 8) begin
            add_str(hdr_names[k]);
            n = $urandom_range(3);
            repeat (n) blk.push_back($urandom_range(1) ? hhfl_pkg::CH_SP : hhfl_pkg::CH_TAB);
            n = $urandom_range(12);
            for (i = 0; i < n; i++) begin
                if (sel == 8 && $urandom_range(2) == 0) begin
                    // lone CR, lone LF or a zero byte inside the value
                    case ($urandom_range(2))
                        0: begin
                            blk.push_back(hhfl_pkg::CH_CR);
                            blk.push_back(pick_char(1'b0));
                        end
                        1: blk.push_back(hhfl_pkg::CH_LF);
                        default: blk.push_back(8'h00);
                    endcase
                end else begin
                    blk.push_back(pick_char(1'b0));
                end
            end
            if ($urandom_range(3) == 0) blk.push_back(hhfl_pkg::CH_SP);
        end else if (sel == 5) begin
            nm = hdr_names[k].substr(0, hdr_names[k].len() - 2);
            case ($urandom_range(2))
                0: nm[0] = nm[0] ^ 8'h20;
                1: nm = nm.substr(0, nm.len() - 2);
                default: nm = {nm, "x"};
            endcase
            add_str(nm);
            blk.push_back(hhfl_pkg::CH_COLON);
            add_text($urandom_range(6), 1'b0);
        end else if (sel == 6) begin
            add_str("X-");
            add_text($urandom_range(1, 12), 1'b1);
            blk.push_back(hhfl_pkg::CH_COLON);
            add_text($urandom_range(8), 1'b0);
        end else if (sel == 7) begin
            // long enough at times to saturate the name index
            add_text($urandom_range(40), 1'b1);
        end else begin
            n = $urandom_range(1, 20);
            repeat (n) blk.push_back(pick_char(1'b1));
        end
        add_crlf();
    endtask

    task automatic queue_block();
        int    i;
        t_word w;
        for (i = 0; i < blk.size(); i++) begin
            w.data = blk[i];
            w.last = (i == blk.size() - 1);
            tx_q.push_back(w);
        end
    endtask

    task automatic gen_block();
        int n, i;
        blk.delete();
        if ($urandom_range(9) < 2) begin
            n = $urandom_range(1, 40);
            repeat (n) blk.push_back(pick_char(1'b1));
        end else begin
            add_str("GET /");
            add_text($urandom_range(20), 1'b0);
            add_crlf();
            n = $urandom_range(6);
            for (i = 0; i < n; i++) add_header_line();
            case ($urandom_range(3))
                0: begin
                    add_crlf();
                    n = $urandom_range(4);
                    repeat (n) blk.push_back(pick_char(1'b1));
                end
                1: ;  // final LF closes the block
                2: add_text($urandom_range(1, 10), 1'b0);
                default: begin
                    n = $urandom_range(1, blk.size());
                    while (blk.size() > n) void'(blk.pop_back());
                end
            endcase
        end
        queue_block();
    endtask

    // check between edges, once every update of the last edge has settled
    task automatic drain();
        while (tx_q.size() != 0 || i_s_axis_tvalid || rec_q.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin : stimulus
        int tx_plan [3];
        int rx_plan [3];
        int ph, made;
        tx_plan = '{37, 75, 0};
        rx_plan = '{75, 37, 0};
        parser_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // blank line closes, trailing byte ignored
        blk.delete();
        add_str("A");
        add_crlf();
        add_str("Host: x");
        add_crlf();
        add_crlf();
        add_str("Z");
        queue_block();
        // single byte, no line end at all
        blk.delete();
        blk.push_back(8'hFF);
        queue_block();
        // empty request line, then lone CR and lone LF on an unterminated line
        blk.delete();
        add_crlf();
        add_str("X");
        blk.push_back(hhfl_pkg::CH_CR);
        add_str("Y");
        blk.push_back(hhfl_pkg::CH_LF);
        queue_block();
        drain();

        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct <= tx_plan[ph];
            rx_idle_pct <= rx_plan[ph];
            run_phase   <= ph + 1;
            made = 0;
            while (made < PHASE_BYTES) begin
                gen_block();
                made += blk.size();
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== http_header_field_locator.f =====
rtl/hhfl_pkg.sv
rtl/hhfl_name_match.sv
rtl/http_header_field_locator.sv
verif/tb_top.sv
